// ===== rtl/bwt_backward_search_count_core_defines.svh =====
// assertion macros shared by the checker
`ifndef BWT_BACKWARD_SEARCH_COUNT_CORE_DEFINES_SVH
`define BWT_BACKWARD_SEARCH_COUNT_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle (consequent may carry a delay)
`define BBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define BBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bbs_pkg.sv =====
package bbs_pkg;

   localparam int NUM_SYM       = 5;
   localparam int SYMBOL_W      = 3;
   localparam int MATCH_COUNT_W = 11;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_PATTERN = 1'b1;

   typedef struct packed {
      logic load;
      logic issue;
      logic finish;
      logic lookup;
      logic respond;
   } bbs_cmd_type;

endpackage

// ===== rtl/bbs_ctrl.sv =====
module bbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   input  logic                 req_func,
   input  logic                 req_last,
   output logic                 busy,
   output bbs_pkg::bbs_cmd_type cmd
);
   import bbs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FINISH,
      ST_LOOKUP
   } state_type;

   state_type state_ff;
   logic      last_ff;
   logic      accept;

   assign accept = req_start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.load    = accept && (req_func == FUNC_LOAD);
      cmd.issue   = accept && (req_func == FUNC_PATTERN);
      cmd.finish  = (state_ff == ST_FINISH);
      cmd.lookup  = (state_ff == ST_LOOKUP);
      cmd.respond = (state_ff == ST_LOOKUP) && last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  last_ff <= req_last;
                  if (req_func == FUNC_PATTERN) begin
                     state_ff <= ST_LOOKUP;
                  end else if (req_last) begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               state_ff <= ST_IDLE;
            end
            ST_LOOKUP: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/bbs_datapath.sv =====
module bbs_datapath #(
   parameter int MAX_TEXT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bbs_pkg::bbs_cmd_type               cmd,
   input  logic [bbs_pkg::SYMBOL_W-1:0]       req_symbol,
   output logic                               rsp_strobe,
   output logic [bbs_pkg::MATCH_COUNT_W-1:0]  rsp_match_count
);
   import bbs_pkg::*;

   localparam int W     = $clog2(MAX_TEXT + 1);
   localparam int DEPTH = MAX_TEXT + 1;

   // occurrence table, one row of per-symbol counts per text position
   logic [NUM_SYM-1:0][W-1:0] occ_mem [DEPTH];

   logic [NUM_SYM-1:0][W-1:0] counts_ff;
   logic [NUM_SYM-1:0][W-1:0] start_ff;
   logic [W-1:0]              len_ff;
   logic [W-1:0]              top_ff;
   logic [W-1:0]              end_ff;
   logic                      empty_ff;
   logic                      load_done_ff;

   logic [NUM_SYM-1:0][W-1:0] rd_top_ff;
   logic [NUM_SYM-1:0][W-1:0] rd_end_ff;
   logic                      top_zero_ff;
   logic                      end_zero_ff;
   logic [SYMBOL_W-1:0]       sym_ff;

   logic                      rsp_strobe_ff;
   logic [MATCH_COUNT_W-1:0]  match_count_ff;

   // load path
   logic [NUM_SYM-1:0][W-1:0] base_counts;
   logic [NUM_SYM-1:0][W-1:0] counts_in;
   logic [W-1:0]              base_len;
   logic [W-1:0]              len_in;
   logic                      grow;

   // start table build
   logic [NUM_SYM-1:0][W-1:0] start_in;
   logic [W-1:0]              acc;

   // lookup path
   logic [W-1:0]              occ_a;
   logic [W-1:0]              occ_b;
   logic [W-1:0]              start_sel;
   logic                      sym_valid;
   logic                      skip;
   logic                      hit;
   logic [W-1:0]              diff;
   logic [W+MATCH_COUNT_W-1:0] diff_wide;

   always_comb begin
      base_counts = load_done_ff ? '0 : counts_ff;
      base_len    = load_done_ff ? '0 : len_ff;
      grow        = (req_symbol < SYMBOL_W'(NUM_SYM)) && (base_len < W'(MAX_TEXT));
      counts_in   = base_counts;
      for (int i = 0; i < NUM_SYM; i++) begin
         if (grow && (req_symbol == SYMBOL_W'(i))) begin
            counts_in[i] = base_counts[i] + W'(1);
         end
      end
      len_in = base_len + W'(grow);
   end

   always_comb begin
      acc = '0;
      start_in = '0;
      for (int i = 0; i < NUM_SYM; i++) begin
         start_in[i] = acc;
         acc = acc + counts_ff[i];
      end
   end

   always_comb begin
      occ_a     = '0;
      occ_b     = '0;
      start_sel = '0;
      sym_valid = 1'b0;
      for (int i = 0; i < NUM_SYM; i++) begin
         if (sym_ff == SYMBOL_W'(i)) begin
            occ_a     = top_zero_ff ? '0 : rd_top_ff[i];
            occ_b     = end_zero_ff ? '0 : rd_end_ff[i];
            start_sel = start_ff[i];
            sym_valid = 1'b1;
         end
      end
      skip = empty_ff || !load_done_ff || !sym_valid
          || (top_ff > W'(MAX_TEXT)) || (end_ff > W'(MAX_TEXT));
      hit       = !skip && (occ_a < occ_b);
      diff      = occ_b - occ_a;
      diff_wide = {{MATCH_COUNT_W{1'b0}}, diff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load && grow) begin
         occ_mem[len_in] <= counts_in;
      end
      if (cmd.issue) begin
         rd_top_ff <= occ_mem[top_ff];
         rd_end_ff <= occ_mem[end_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         sym_ff      <= req_symbol;
         top_zero_ff <= (top_ff == '0);
         end_zero_ff <= (end_ff == '0);
      end
      if (cmd.respond) begin
         match_count_ff <= hit ? diff_wide[MATCH_COUNT_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff     <= '0;
         start_ff      <= '0;
         len_ff        <= '0;
         top_ff        <= '0;
         end_ff        <= '0;
         empty_ff      <= 1'b0;
         load_done_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
         if (cmd.load) begin
            counts_ff    <= counts_in;
            len_ff       <= len_in;
            load_done_ff <= 1'b0;
         end
         if (cmd.finish) begin
            start_ff     <= start_in;
            load_done_ff <= 1'b1;
            top_ff       <= '0;
            end_ff       <= len_ff;
            empty_ff     <= (len_ff == '0);
         end
         if (cmd.lookup) begin
            if (cmd.respond) begin
               // re-arm to the whole text for the next pattern
               top_ff   <= '0;
               end_ff   <= len_ff;
               empty_ff <= (len_ff == '0) || !load_done_ff;
            end else if (hit) begin
               top_ff <= start_sel + occ_a;
               end_ff <= start_sel + occ_b;
            end else begin
               empty_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_match_count = match_count_ff;

endmodule

// ===== rtl/bwt_backward_search_count_core.sv =====
// load symbol: taken busy-free; the last load symbol also passes through a finish state to build the start table
// pattern symbol: occurrence table read, then interval update in the lookup state, one at a time
// match count strobe is registered from the lookup state of the last pattern symbol; receiver cannot stall
// synchronous active-high reset clears control and counts; the occurrence table is not cleared
module bwt_backward_search_count_core #(
   parameter int MAX_TEXT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_start,
   input  logic                              req_func,
   input  logic [bbs_pkg::SYMBOL_W-1:0]      req_symbol,
   input  logic                              req_last,
   output logic                              busy,
   output logic                              rsp_strobe,
   output logic [bbs_pkg::MATCH_COUNT_W-1:0] rsp_match_count
);
   import bbs_pkg::*;

   bbs_cmd_type cmd;

   bbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .req_func  (req_func),
      .req_last  (req_last),
      .busy      (busy),
      .cmd       (cmd)
   );

   bbs_datapath #(
      .MAX_TEXT (MAX_TEXT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_symbol      (req_symbol),
      .rsp_strobe      (rsp_strobe),
      .rsp_match_count (rsp_match_count)
   );

endmodule

// ===== rtl/bbs_checker.sv =====
`include "bwt_backward_search_count_core_defines.svh"

module bbs_checker (
   input logic clock,
   input logic reset,
   input logic req_start,
   input logic req_func,
   input logic req_last,
   input logic busy,
   input logic rsp_strobe
);
   import bbs_pkg::*;

   logic pat_accept;
   logic load_accept;
   logic pat_last;
   logic pat_mid;

   assign pat_accept  = req_start && !busy && (req_func == FUNC_PATTERN);
   assign load_accept = req_start && !busy && (req_func == FUNC_LOAD);
   assign pat_last    = pat_accept && req_last;
   assign pat_mid     = pat_accept && !req_last;

   `BBS_ASSERT_IMP(a_last_pattern_answers, clock, reset, pat_last, ##2 rsp_strobe, "no answer")
   `BBS_ASSERT_IMP(a_mid_pattern_silent, clock, reset, pat_mid, ##2 !rsp_strobe, "early answer")
   `BBS_ASSERT_NEXT(a_load_silent, clock, reset, load_accept, !rsp_strobe, "answer after a load")
   `BBS_ASSERT_IMP(a_answer_follows_busy, clock, reset, rsp_strobe, $past(busy) && !busy, "stray")

endmodule

bind bwt_backward_search_count_core bbs_checker u_checker (.*);

// ===== verif/bwt_backward_search_count_core_tb.sv =====
module bwt_backward_search_count_core_tb;
   import bbs_pkg::*;

   localparam int MAX_TEXT    = 1024;
   localparam int ITEM_TARGET = 1850;
   localparam int BIG_LOAD    = 1100;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 8;
   localparam int MAX_GAP     = 16;

   localparam logic [SYMBOL_W-1:0] SYM_END    = 3'd0;
   localparam logic [SYMBOL_W-1:0] SYM_A      = 3'd1;
   localparam logic [SYMBOL_W-1:0] SYM_C      = 3'd2;
   localparam logic [SYMBOL_W-1:0] SYM_G      = 3'd3;
   localparam logic [SYMBOL_W-1:0] SYM_T      = 3'd4;
   localparam logic [SYMBOL_W-1:0] SYM_BAD_LO = 3'd5;
   localparam logic [SYMBOL_W-1:0] SYM_BAD_HI = 3'd7;

   typedef logic [MATCH_COUNT_W-1:0] count_type;

   typedef struct {
      logic                func;
      logic [SYMBOL_W-1:0] symbol;
      logic                is_last;
   } search_item_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_start = 1'b0;
   logic                     req_func = FUNC_LOAD;
   logic [SYMBOL_W-1:0]      req_symbol = '0;
   logic                     req_last = 1'b0;
   logic                     busy;
   logic                     rsp_strobe;
   logic [MATCH_COUNT_W-1:0] rsp_match_count;

   search_item_type pending_items[$];
   search_item_type cur_item;
   count_type       expected_counts[$];
   int              idle_left = 0;
   int              next_gap;
   int              calm_left = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;

   // search model state
   count_type occ_rows[0:MAX_TEXT][0:NUM_SYM-1];
   count_type sym_totals[NUM_SYM];
   count_type sym_base[NUM_SYM];
   count_type text_len;
   count_type row_top;
   count_type row_end;
   bit        range_empty;
   bit        text_ready;

   bwt_backward_search_count_core #(.MAX_TEXT(MAX_TEXT)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_start       (req_start),
      .req_func        (req_func),
      .req_symbol      (req_symbol),
      .req_last        (req_last),
      .busy            (busy),
      .rsp_strobe      (rsp_strobe),
      .rsp_match_count (rsp_match_count)
   );

   always #5 clock = ~clock;

   function automatic void clear_text();
      for (int c = 0; c < NUM_SYM; c++) begin
         sym_totals[c]  = '0;
         sym_base[c]    = '0;
         occ_rows[0][c] = '0;
      end
      text_len   = '0;
      text_ready = 1'b0;
   endfunction

   function automatic void rearm_range();
      row_top     = '0;
      row_end     = text_len;
      range_empty = (text_len == 0) || !text_ready;
   endfunction

   function automatic void predict_transaction(search_item_type it);
      count_type rank_top;
      count_type rank_end;
      count_type acc;
      if (it.func == FUNC_LOAD) begin
         if (text_ready) clear_text();
         if (it.symbol < NUM_SYM && text_len < MAX_TEXT) begin
            sym_totals[it.symbol]++;
            text_len++;
            for (int c = 0; c < NUM_SYM; c++) occ_rows[text_len][c] = sym_totals[c];
         end
         if (it.is_last) begin
            acc = '0;
            for (int c = 0; c < NUM_SYM; c++) begin
               sym_base[c] = acc;
               acc += sym_totals[c];
            end
            text_ready = 1'b1;
            rearm_range();
         end
      end else begin
         if (!text_ready) range_empty = 1'b1;
         if (!range_empty) begin
            if (it.symbol >= NUM_SYM) begin
               range_empty = 1'b1;
            end else begin
               rank_top = occ_rows[row_top][it.symbol];
               rank_end = occ_rows[row_end][it.symbol];
               if (rank_top < rank_end) begin
                  row_top = sym_base[it.symbol] + rank_top;
                  row_end = sym_base[it.symbol] + rank_end;
               end else begin
                  range_empty = 1'b1;
               end
            end
         end
         if (it.is_last) begin
            expected_counts.push_back(range_empty ? count_type'(0)
                                                  : count_type'(row_end - row_top));
            rearm_range();
         end
      end
   endfunction

   function automatic void queue_item(logic f, logic [SYMBOL_W-1:0] s, logic l);
      search_item_type it;
      it.func    = f;
      it.symbol  = s;
      it.is_last = l;
      pending_items.push_back(it);
   endfunction

   function automatic logic [SYMBOL_W-1:0] bad_symbol();
      return SYMBOL_W'($urandom_range(SYM_BAD_LO, SYM_BAD_HI));
   endfunction

   // a few invalid codes, otherwise the full alphabet
   function automatic logic [SYMBOL_W-1:0] text_symbol();
      if ($urandom_range(0, 19) == 0) return bad_symbol();
      return SYMBOL_W'($urandom_range(SYM_END, SYM_T));
   endfunction

   function automatic logic [SYMBOL_W-1:0] pattern_symbol();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return bad_symbol();
      if (pick < 12) return SYM_END;
      return SYMBOL_W'($urandom_range(SYM_A, SYM_T));
   endfunction

   // idle-free stretches now and then
   function automatic int draw_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
         idle_left <= 0;
      end else if (req_start) begin
         if (!busy) begin
            predict_transaction(cur_item);
            next_gap = draw_gap();
            if (pending_items.size() != 0 && next_gap == 0) begin
               cur_item = pending_items.pop_front();
               req_func   <= cur_item.func;
               req_symbol <= cur_item.symbol;
               req_last   <= cur_item.is_last;
            end else begin
               req_start <= 1'b0;
               idle_left <= next_gap;
            end
         end
      end else if (idle_left != 0) begin
         idle_left <= idle_left - 1;
      end else if (pending_items.size() != 0) begin
         cur_item = pending_items.pop_front();
         req_func   <= cur_item.func;
         req_symbol <= cur_item.symbol;
         req_last   <= cur_item.is_last;
         req_start  <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_counts.size() == 0) begin
            note_mismatch($sformatf("unexpected match count %0d", rsp_match_count));
         end else if (rsp_match_count !== expected_counts[0]) begin
            note_mismatch($sformatf("match_count: expected %0d, got %0d",
                                    expected_counts[0], rsp_match_count));
            void'(expected_counts.pop_front());
         end else begin
            void'(expected_counts.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int pick;
      int len;
      clear_text();
      row_top     = '0;
      row_end     = '0;
      range_empty = 1'b0;

      // pattern before any transform is loaded
      queue_item(FUNC_PATTERN, SYM_A, 1'b1);
      // empty transform: only an invalid code carrying the last flag
      queue_item(FUNC_LOAD, SYM_BAD_LO + 3'd1, 1'b1);
      queue_item(FUNC_PATTERN, SYM_C, 1'b1);
      // short transform with a dropped code in the middle
      queue_item(FUNC_LOAD, SYM_A, 1'b0);
      queue_item(FUNC_LOAD, SYM_G, 1'b0);
      queue_item(FUNC_LOAD, SYM_T, 1'b0);
      queue_item(FUNC_LOAD, SYM_BAD_HI, 1'b0);
      queue_item(FUNC_LOAD, SYM_END, 1'b0);
      queue_item(FUNC_LOAD, SYM_C, 1'b0);
      queue_item(FUNC_LOAD, SYM_A, 1'b0);
      queue_item(FUNC_LOAD, SYM_A, 1'b1);
      queue_item(FUNC_PATTERN, SYM_A, 1'b1);
      queue_item(FUNC_PATTERN, SYM_A, 1'b0);
      queue_item(FUNC_PATTERN, SYM_C, 1'b1);
      // invalid pattern code empties the interval
      queue_item(FUNC_PATTERN, SYM_BAD_LO, 1'b0);
      queue_item(FUNC_PATTERN, SYM_A, 1'b1);
      queue_item(FUNC_PATTERN, SYM_END, 1'b1);
      // interval runs dry and stays so
      repeat (3) queue_item(FUNC_PATTERN, SYM_T, 1'b0);
      queue_item(FUNC_PATTERN, SYM_T, 1'b1);
      // fresh load cuts into an open pattern
      queue_item(FUNC_PATTERN, SYM_G, 1'b0);
      queue_item(FUNC_LOAD, SYM_T, 1'b1);
      queue_item(FUNC_PATTERN, SYM_T, 1'b1);

      // transform longer than the table holds
      for (int i = 0; i < BIG_LOAD; i++) queue_item(FUNC_LOAD, text_symbol(), i == BIG_LOAD - 1);
      repeat (20) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) queue_item(FUNC_PATTERN, pattern_symbol(), i == len - 1);
      end

      while (pending_items.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               queue_item(FUNC_PATTERN, pattern_symbol(), i == len - 1);
         end else if (pick < 80) begin
            len = $urandom_range(0, 40);
            if (len == 0) queue_item(FUNC_LOAD, bad_symbol(), 1'b1);
            for (int i = 0; i < len; i++) queue_item(FUNC_LOAD, text_symbol(), i == len - 1);
         end else if (pick < 90) begin
            // load left open, later items join or interrupt it
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) queue_item(FUNC_LOAD, text_symbol(), 1'b0);
         end else begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) queue_item(FUNC_PATTERN, pattern_symbol(), 1'b0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_start || expected_counts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && expected_counts.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
